>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define TPTE_ASSERT(name, a_clk, a_rst_n, prop) \
    name: assert property (@(posedge a_clk) disable iff (!a_rst_n) prop) \
        else $error("tpte check failed");

// clocked check that also holds while reset is asserted
`define TPTE_ASSERT_ALWAYS(name, a_clk, prop) \
    name: assert property (@(posedge a_clk) prop) \
        else $error("tpte check failed during reset");

`endif

>>> sv/tpte_pkg.sv
// ----------------------------------------------------------------------------
// tpte_pkg
// shared types and constants of the tape pulse encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpte_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CPS_W      = 24;
    localparam int CPS_FRAC   = 16;
    localparam int TAP_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_W      = 17;
    localparam int QUEUE_DEPTH = 2;

    localparam int FRAC_BITS_DEF       = 8;
    localparam int TAP_UNIT_CYCLES_DEF = 8;
    localparam int POSITION_BITS_DEF   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPS   = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] UPPER_RST = 16'sd3277;
    localparam logic signed [SAMPLE_W-1:0] LOWER_RST = -16'sd3277;
    localparam logic [CPS_W-1:0]           CPS_RST   = 24'd1464154;

    localparam logic [CPS_W-1:0] CYCLE_MAX     = 24'hFFFFFF;
    localparam logic [TAP_W-1:0] TAP_LONG_MARK = 8'h00;

    // crossing fraction job: numerator below denominator, denominator nonzero
    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_job_t;

endpackage

`default_nettype wire

>>> sv/tpte_fifo.sv
// ----------------------------------------------------------------------------
// tpte_fifo
// short show-ahead queue between the flank detector and the pulse encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpte_fifo
    import tpte_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/tpte_front.sv
// ----------------------------------------------------------------------------
// tpte_front
// config registers, hysteresis comparator and down-flank detection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpte_front
    import tpte_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]      s_axis_tdata,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    output logic      [CPS_W-1:0]         cps,
    output logic                          job_valid,
    input  wire logic                     job_full,
    output div_job_t                      job,
    output logic      [POSITION_BITS-1:0] job_pos
);

    logic signed [SAMPLE_W-1:0] upper_reg, upper_next;
    logic signed [SAMPLE_W-1:0] lower_reg, lower_next;
    logic        [CPS_W-1:0]    cps_reg, cps_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic                       above_reg, above_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;

    logic signed [SAMPLE_W-1:0] sample_s;
    logic                       accept, is_high, is_low, div_ok;
    logic        [DIV_W-1:0]    num_w, den_w;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !job_full;
    assign accept        = s_axis_tvalid && !job_full;
    assign sample_s      = signed'(s_axis_tdata);
    assign is_high       = sample_s > upper_reg;
    assign is_low        = sample_s < lower_reg;
    assign cps           = cps_reg;

    // interpolation operands, forced to a zero fraction when out of range
    assign num_w  = {prev_reg[SAMPLE_W-1], prev_reg} - {lower_reg[SAMPLE_W-1], lower_reg};
    assign den_w  = {prev_reg[SAMPLE_W-1], prev_reg} - {sample_s[SAMPLE_W-1], sample_s};
    assign div_ok = !num_w[DIV_W-1] && !den_w[DIV_W-1] && (den_w != '0);

    assign job.num   = div_ok ? num_w : '0;
    assign job.den   = div_ok ? den_w : DIV_W'(1);
    assign job_pos   = pos_reg - {{(POSITION_BITS-1){1'b0}}, 1'b1};
    assign job_valid = accept && !is_high && is_low && above_reg;

    always_comb
    begin
        upper_next = upper_reg;
        lower_next = lower_reg;
        cps_next   = cps_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_UPPER: upper_next = signed'(cfg_data[SAMPLE_W-1:0]);
                REG_LOWER: lower_next = signed'(cfg_data[SAMPLE_W-1:0]);
                REG_CPS:   cps_next   = cfg_data[CPS_W-1:0];
                default:   cps_next   = cps_reg;
            endcase
        end
    end

    always_comb
    begin
        prev_next  = prev_reg;
        above_next = above_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            if (is_high)
            begin
                above_next = 1'b1;
            end
            else if (is_low)
            begin
                above_next = 1'b0;
            end
            prev_next = sample_s;
            pos_next  = pos_reg + {{(POSITION_BITS-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_RST;
            lower_reg <= LOWER_RST;
            cps_reg   <= CPS_RST;
            prev_reg  <= '0;
            above_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            upper_reg <= upper_next;
            lower_reg <= lower_next;
            cps_reg   <= cps_next;
            prev_reg  <= prev_next;
            above_reg <= above_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/tpte_back.sv
// ----------------------------------------------------------------------------
// tpte_back
// serial crossing divider, cycle scaler, length step and byte emitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpte_back
    import tpte_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int TAP_UNIT_CYCLES = TAP_UNIT_CYCLES_DEF,
    parameter int POSITION_BITS   = POSITION_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     job_empty,
    input  wire div_job_t                 job,
    input  wire logic [POSITION_BITS-1:0] job_pos,
    output logic                          job_pop,
    input  wire logic [CPS_W-1:0]         cps,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic      [TAP_W-1:0]         m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam int DW     = POSITION_BITS + FRAC_BITS;
    localparam int SH     = FRAC_BITS + CPS_FRAC;
    localparam int CW     = CPS_W + SH;
    localparam int SW     = ((CW + 1 > DW) ? CW + 1 : DW) + 1;
    localparam int NW     = CPS_W + 2;
    localparam int STEP_W = $clog2(NW);

    // pulse length by reciprocal multiplication, exact below the long-form limit
    localparam int DIVISOR = 2 * TAP_UNIT_CYCLES;
    localparam int DIV_SH  = $clog2(DIVISOR);
    localparam int LEN_N   = TAP_W + DIV_SH;
    localparam int RK      = LEN_N + DIV_SH;

    localparam logic [RK-1:0] RECIP      =
        RK'(((longint'(1) << RK) + longint'(DIVISOR) - 1) / longint'(DIVISOR));
    localparam logic [NW-1:0] LONG_LIMIT = NW'(DIVISOR << TAP_W);
    localparam logic [CW:0]   HALF       = {{(CW+1-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FRAC = 3'd1;
    localparam logic [2:0] ST_POS  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_RND  = 3'd4;
    localparam logic [2:0] ST_LEN  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0]               state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [DIV_W-1:0]         den_reg, den_next;
    logic [FRAC_BITS-1:0]     frac_reg, frac_next;
    logic [POSITION_BITS-1:0] spm1_reg, spm1_next;
    logic [DW-1:0]            last_reg, last_next;
    logic                     have_reg, have_next;
    logic [DW-1:0]            d_reg, d_next;
    logic [CW-1:0]            acc_reg, acc_next;
    logic                     sat_reg, sat_next;
    logic [CPS_W-1:0]         mul_reg, mul_next;
    logic [CPS_W-1:0]         cyc_reg, cyc_next;
    logic [NW-1:0]            nq_reg, nq_next;
    logic [1:0]               idx_reg, idx_next;
    logic                     long_reg, long_next;
    logic                     ovalid_reg, ovalid_next;
    logic [TAP_W-1:0]         obyte_reg, obyte_next;
    logic                     olast_reg, olast_next;

    logic [DIV_W:0]           rem_sh, rem_diff;
    logic                     rem_ge;
    logic [DW-1:0]            flank_pos;
    logic [SW-1:0]            mul_sum;
    logic [CW:0]              rnd_sum;
    logic [CPS_W:0]           cyc_wide;
    logic [CPS_W-1:0]         cyc_sat;
    logic [LEN_N+RK-1:0]      len_prod;
    logic                     len_long;
    logic                     load;
    logic [TAP_W-1:0]         sel_byte;
    logic                     sel_last;

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = obyte_reg;
    assign m_axis_tlast  = olast_reg;
    assign job_pop       = (state_reg == ST_IDLE) && !job_empty;

    // restoring division step for the crossing fraction
    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    assign flank_pos = {spm1_reg, frac_reg};

    // msb-first shift-add, cps bit by bit
    assign mul_sum = {{(SW-CW-1){1'b0}}, acc_reg, 1'b0}
                   + (mul_reg[CPS_W-1] ? {{(SW-DW){1'b0}}, d_reg} : SW'(0));

    assign rnd_sum  = {1'b0, acc_reg} + HALF;
    assign cyc_wide = rnd_sum[CW:SH];
    assign cyc_sat  = (sat_reg || cyc_wide[CPS_W]) ? CYCLE_MAX : cyc_wide[CPS_W-1:0];

    // length = (2 * cycles + unit) / (2 * unit), only needed below the limit
    assign len_prod = {{RK{1'b0}}, nq_reg[LEN_N-1:0]} * {{LEN_N{1'b0}}, RECIP};
    assign len_long = nq_reg >= LONG_LIMIT;

    assign load = !ovalid_reg || m_axis_tready;

    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                sel_byte = long_reg ? TAP_LONG_MARK : nq_reg[TAP_W-1:0];
                sel_last = !long_reg;
            end
            2'd1:
            begin
                sel_byte = cyc_reg[7:0];
                sel_last = 1'b0;
            end
            2'd2:
            begin
                sel_byte = cyc_reg[15:8];
                sel_last = 1'b0;
            end
            default:
            begin
                sel_byte = cyc_reg[23:16];
                sel_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        frac_next   = frac_reg;
        spm1_next   = spm1_reg;
        last_next   = last_reg;
        have_next   = have_reg;
        d_next      = d_reg;
        acc_next    = acc_reg;
        sat_next    = sat_reg;
        mul_next    = mul_reg;
        cyc_next    = cyc_reg;
        nq_next     = nq_reg;
        idx_next    = idx_reg;
        long_next   = long_reg;
        ovalid_next = m_axis_tready ? 1'b0 : ovalid_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    rem_next   = job.num;
                    den_next   = job.den;
                    spm1_next  = job_pos;
                    frac_next  = '0;
                    step_next  = '0;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                rem_next  = rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
                frac_next = {frac_reg[FRAC_BITS-2:0], rem_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRAC_BITS - 1))
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                d_next    = flank_pos - last_reg;
                last_next = flank_pos;
                have_next = 1'b1;
                acc_next  = '0;
                sat_next  = 1'b0;
                mul_next  = cps;
                step_next = '0;
                // first flank only records its place
                state_next = have_reg ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                if (|mul_sum[SW-1:CW])
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = mul_sum[CW-1:0];
                end
                mul_next  = {mul_reg[CPS_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CPS_W - 1))
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                cyc_next   = cyc_sat;
                nq_next    = {1'b0, cyc_sat, 1'b0} + NW'(TAP_UNIT_CYCLES);
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                nq_next    = {{(NW-LEN_N){1'b0}}, len_prod[LEN_N+RK-1:RK]};
                long_next  = len_long;
                idx_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = sel_byte;
                    olast_next  = sel_last;
                    idx_next    = idx_reg + 1'b1;
                    if (sel_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            have_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            last_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            have_reg   <= have_next;
            ovalid_reg <= ovalid_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        frac_reg  <= frac_next;
        spm1_reg  <= spm1_next;
        d_reg     <= d_next;
        acc_reg   <= acc_next;
        sat_reg   <= sat_next;
        mul_reg   <= mul_next;
        cyc_reg   <= cyc_next;
        nq_reg    <= nq_next;
        idx_reg   <= idx_next;
        long_reg  <= long_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

endmodule

`default_nettype wire

>>> sv/tape_pulse_tap_encoder.sv
// ----------------------------------------------------------------------------
// tape_pulse_tap_encoder
// turns signed audio samples into tap v1 pulse-length bytes
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one 16-bit signed sample per transfer; m_axis carries one
//   tap byte per transfer, tlast marks the final byte of a pulse
//   cfg port writes upper threshold (0), lower threshold (1) and
//   cycles per sample (2, Q8.16); cfg_ready is always high
//   samples are taken one per cycle while the flank queue has room; a sample
//   without a down-flank costs nothing further
//   each down-flank holds the encoder for the pop, the bit-serial fraction
//   divider (FRAC_BITS steps), the position step, the 24-step cycle scaler,
//   the rounding and length steps and the emission of its bytes; a newer
//   flank waits in the queue until the encoder is back in idle
//   a short pulse gives one byte, a long one a zero byte and three count bytes
//   the first flank after reset gives no bytes
//   when m_axis stalls the byte holds in the output register; the queue
//   (two flanks deep) fills, then s_axis_tready drops
//   reset clears the comparator, sample counter and queue and loads the
//   default register values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tape_pulse_tap_encoder
    import tpte_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int TAP_UNIT_CYCLES = TAP_UNIT_CYCLES_DEF,
    parameter int POSITION_BITS   = POSITION_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // sample stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
    // tap byte stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [TAP_W-1:0]      m_axis_tdata,   // [7:0] tap_byte
    output logic                       m_axis_tlast,   // last_of_pulse
    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // queue entry: crossing operands plus the index of the previous sample
    localparam int JOB_W = $bits(div_job_t) + POSITION_BITS;

    logic                     push, full, pop, empty;
    div_job_t                 front_job, back_job;
    logic [POSITION_BITS-1:0] front_pos, back_pos;
    logic [CPS_W-1:0]         cps;
    logic [JOB_W-1:0]         q_wr, q_rd;

    // front: comparator and flank detection, one sample per cycle while the flank queue has room
    tpte_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cps           (cps),
        .job_valid     (push),
        .job_full      (full),
        .job           (front_job),
        .job_pos       (front_pos)
    );

    assign q_wr     = {front_pos, front_job};
    assign back_pos = q_rd[JOB_W-1:$bits(div_job_t)];
    assign back_job = q_rd[$bits(div_job_t)-1:0];

    // flank queue decouples detection from encoding
    tpte_fifo #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (q_wr),
        .full    (full),
        .rd_en   (pop),
        .rd_data (q_rd),
        .empty   (empty)
    );

    // back: interpolation, scaling and byte emission
    tpte_back #(
        .FRAC_BITS       (FRAC_BITS),
        .TAP_UNIT_CYCLES (TAP_UNIT_CYCLES),
        .POSITION_BITS   (POSITION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_empty     (empty),
        .job           (back_job),
        .job_pos       (back_pos),
        .job_pop       (pop),
        .cps           (cps),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> sv/tpte_checker.sv
// ----------------------------------------------------------------------------
// tpte_checker
// port-level checks on the tape pulse encoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tpte_checker
    import tpte_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [SAMPLE_W-1:0]   s_axis_tdata,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [TAP_W-1:0]      m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    // a stalled byte stays offered
    `TPTE_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

    // a stalled byte keeps its value
    `TPTE_ASSERT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // bytes of one pulse leave without gaps
    `TPTE_ASSERT(a_pulse_burst, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)

    // a clock edge that sees reset asserted leaves nothing offered
    `TPTE_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_axis_tvalid)

endmodule

bind tape_pulse_tap_encoder tpte_checker u_checker (.*);

`default_nettype wire

>>> tb/tape_pulse_tap_encoder_tb.sv
// ----------------------------------------------------------------------------
// tape_pulse_tap_encoder_tb
// self-checking bench for the sample to tap byte encoder
// ----------------------------------------------------------------------------
// samples go in over s_axis from a queue that the stimulus block fills; a
// clocked driver and a clocked receiver add random idle cycles on both sides.
// every accepted sample runs through a bench-side comparator and pulse
// scaler, whose tap bytes are held in order and compared with each m_axis
// transfer. threshold and scale registers change between phases, only
// while the encoder is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tape_pulse_tap_encoder_tb;
    import tpte_pkg::*;

    localparam int FRAC_W   = FRAC_BITS_DEF;
    localparam int POS_W    = POSITION_BITS_DEF;
    localparam int FIX_W    = POS_W + FRAC_W;
    localparam int TAP_UNIT = TAP_UNIT_CYCLES_DEF;

    // largest pulse length that still fits a single tap byte
    localparam int TAP_SHORT_MAX = 255;

    // index 3 has no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int SETTLE_CYCLES    = 2 * (FRAC_W + 54) + 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 5000;
    localparam int RANDOM_ITEMS     = 80;

    typedef struct packed {
        logic [TAP_W-1:0] tap_byte;
        logic             last_of_pulse;
    } tap_item_t;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        int                  gap;      // idle cycles after this sample
        bit                  drain;    // hold back until every byte is out
    } sample_item_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;   // [15:0] sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TAP_W-1:0]      m_axis_tdata;         // [7:0] tap_byte
    logic                  m_axis_tlast;         // last_of_pulse
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // bench copy of the registers
    logic signed [SAMPLE_W-1:0] thr_upper;
    logic signed [SAMPLE_W-1:0] thr_lower;
    logic [CPS_W-1:0]           scale_cps;

    // bench copy of the comparator and flank tracking
    logic signed [SAMPLE_W-1:0] prev_smp;
    bit                         armed;
    logic [POS_W-1:0]           smp_index;
    logic [FIX_W-1:0]           flank_pos;
    bit                         flank_seen;

    sample_item_t pending_samples[$];
    tap_item_t    tap_expect[$];
    tap_item_t    oldest;
    sample_item_t tx_item;

    // transfer flags of the latest rising edge, read at the falling edge
    bit s_took;
    bit m_took;
    bit cfg_took;

    bit tx_valid_next;
    int tx_gap;
    int rx_wait;
    int rx_gap_max;
    int hold_left;
    int hold_requests;
    int holds_served;

    int items_queued;
    int samples_taken;
    int bytes_checked;
    int short_pulses;
    int long_pulses;
    int saturated_pulses;
    int stall_cycles;
    int errors;

    tape_pulse_tap_encoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // append one expected tap byte
    task automatic expect_byte(input logic [TAP_W-1:0] value, input bit last);
        tap_item_t item;
        item.tap_byte      = value;
        item.last_of_pulse = last;
        tap_expect.insert(tap_expect.size(), item);
    endtask

    // comparator, crossing interpolation and pulse scaling for one sample
    task automatic encode_sample(input logic signed [SAMPLE_W-1:0] s);
        longint                 num;
        longint                 den;
        logic [FRAC_W-1:0]      frac;
        logic [FIX_W-1:0]       pos;
        logic [FIX_W-1:0]       span;
        logic [FIX_W+CPS_W:0]   prod;
        logic [FIX_W+CPS_W:0]   scaled;
        logic [CPS_W-1:0]       cyc;
        int                     len;
        if (s > thr_upper)
            armed = 1'b1;
        else if (s < thr_lower)
        begin
            if (armed)
            begin
                // linear crossing point of the lower threshold
                num  = longint'(prev_smp) - longint'(thr_lower);
                den  = longint'(prev_smp) - longint'(s);
                frac = '0;
                if (num >= 0 && den > 0)
                    frac = FRAC_W'((num << FRAC_W) / den);
                pos = {smp_index - 1'b1, {FRAC_W{1'b0}}} + frac;
                if (flank_seen)
                begin
                    span   = pos - flank_pos;
                    prod   = span * scale_cps + ((FIX_W+CPS_W+1)'(1) << (FRAC_W + CPS_FRAC - 1));
                    scaled = prod >> (FRAC_W + CPS_FRAC);
                    cyc    = (scaled > CYCLE_MAX) ? CYCLE_MAX : scaled[CPS_W-1:0];
                    len    = (2 * int'(cyc) + TAP_UNIT) / (2 * TAP_UNIT);
                    if (len <= TAP_SHORT_MAX)
                    begin
                        expect_byte(TAP_W'(len), 1'b1);
                        short_pulses++;
                    end
                    else
                    begin
                        expect_byte(TAP_LONG_MARK, 1'b0);
                        expect_byte(cyc[7:0], 1'b0);
                        expect_byte(cyc[15:8], 1'b0);
                        expect_byte(cyc[23:16], 1'b1);
                        long_pulses++;
                        if (scaled > CYCLE_MAX)
                            saturated_pulses++;
                    end
                end
                flank_pos  = pos;
                flank_seen = 1'b1;
            end
            armed = 1'b0;
        end
        prev_smp  = s;
        smp_index = smp_index + 1'b1;
    endtask

    // monitor: registers, accepted samples and tap byte checks
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            s_took   = s_axis_tvalid && s_axis_tready;
            m_took   = m_axis_tvalid && m_axis_tready;
            cfg_took = cfg_valid && cfg_ready;
            if (cfg_took)
            begin
                case (cfg_index)
                    REG_UPPER: thr_upper = cfg_data[SAMPLE_W-1:0];
                    REG_LOWER: thr_lower = cfg_data[SAMPLE_W-1:0];
                    REG_CPS:   scale_cps = cfg_data[CPS_W-1:0];
                    default:   ;
                endcase
            end
            if (s_took)
            begin
                samples_taken++;
                encode_sample(s_axis_tdata);
            end
            if (m_took)
            begin
                if (tap_expect.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected tap byte, expected none, actual %02h last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    oldest = tap_expect.pop_front();
                    bytes_checked++;
                    if (m_axis_tdata !== oldest.tap_byte)
                    begin
                        errors++;
                        $display("%0t: tap_byte mismatch, expected %02h actual %02h",
                                 $time, oldest.tap_byte, m_axis_tdata);
                    end
                    if (m_axis_tlast !== oldest.last_of_pulse)
                    begin
                        errors++;
                        $display("%0t: last_of_pulse mismatch, expected %0b actual %0b",
                                 $time, oldest.last_of_pulse, m_axis_tlast);
                    end
                end
            end
            if (s_took || m_took || cfg_took)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // sample driver, gap counted after each transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            tx_valid_next = s_axis_tvalid && !s_took;
            if (!tx_valid_next)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending_samples.size() > 0 &&
                         (!pending_samples[0].drain || tap_expect.size() == 0))
                begin
                    tx_item       = pending_samples.pop_front();
                    s_axis_tdata <= tx_item.sample;
                    tx_gap        = tx_item.gap;
                    tx_valid_next = 1'b1;
                end
            end
            s_axis_tvalid <= tx_valid_next;
        end
    end

    // tap byte receiver, random wait per byte plus requested long holds
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (m_took)
                rx_wait = $urandom_range(rx_gap_max);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        wait (rst_n);
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL tape_pulse_tap_encoder");
        $finish;
    end

    task automatic queue_sample(input int value, input bit no_idle, input bit drain);
        sample_item_t item;
        item.sample = SAMPLE_W'(value);
        item.gap    = no_idle ? 0 : int'($urandom_range(4));
        item.drain  = drain;
        pending_samples.insert(pending_samples.size(), item);
        items_queued++;
    endtask

    // well-formed pulses: high run, optional in-band sample, low run
    task automatic queue_pulses(input int count, input int max_run, input bit no_idle);
        int hi_n;
        int lo_n;
        repeat (count)
        begin
            hi_n = $urandom_range(max_run, 1);
            lo_n = $urandom_range(max_run, 1);
            repeat (hi_n)
                queue_sample(rand_between(int'(thr_upper) + 1, 32767), no_idle, 1'b0);
            if ($urandom_range(1))
                queue_sample(rand_between(int'(thr_lower), int'(thr_upper)), no_idle, 1'b0);
            repeat (lo_n)
                queue_sample(rand_between(-32768, int'(thr_lower) - 1), no_idle, 1'b0);
        end
    endtask

    // wait for every sample and tap byte, then for a flank still in flight
    task automatic wait_quiet();
        while (samples_taken != items_queued || tap_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (!cfg_took)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // unused upper data bits carry junk
    task automatic set_thresholds(input int up, input int lo);
        write_reg(REG_UPPER, {8'($urandom), SAMPLE_W'(up)});
        write_reg(REG_LOWER, {8'($urandom), SAMPLE_W'(lo)});
    endtask

    initial
    begin
        int random_start;
        int phase;
        int up;
        bit no_idle;
        thr_upper  = UPPER_RST;
        thr_lower  = LOWER_RST;
        scale_cps  = CPS_RST;
        prev_smp   = '0;
        armed      = 1'b0;
        smp_index  = '0;
        flank_pos  = '0;
        flank_seen = 1'b0;
        rx_gap_max = 4;
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;

        // reset thresholds: values at the thresholds do not switch
        queue_sample(3277, 1'b0, 1'b0);
        queue_sample(-3277, 1'b0, 1'b0);
        queue_sample(3278, 1'b0, 1'b0);
        queue_sample(-3278, 1'b0, 1'b0);     // first flank, position only
        queue_sample(32767, 1'b0, 1'b0);
        queue_sample(-32768, 1'b0, 1'b0);
        queue_sample(12000, 1'b0, 1'b0);
        queue_sample(8000, 1'b0, 1'b0);
        queue_sample(-20000, 1'b0, 1'b0);
        queue_sample(0, 1'b0, 1'b0);
        wait_quiet();

        // write to the spare index must change nothing
        write_reg(REG_SPARE, 24'h5A5A5A);
        queue_sample(5000, 1'b0, 1'b0);
        queue_sample(-5000, 1'b0, 1'b0);
        wait_quiet();

        // upper below lower: a sample between the two crosses both, high wins
        set_thresholds(-32768, 32767);
        queue_sample(100, 1'b0, 1'b0);
        queue_sample(-32768, 1'b0, 1'b0);
        queue_sample(32767, 1'b0, 1'b0);
        queue_sample(-32768, 1'b0, 1'b0);
        queue_sample(-32768, 1'b0, 1'b0);
        wait_quiet();

        // thresholds moved between a high sample and the flank
        set_thresholds(3277, -3277);
        queue_sample(5000, 1'b0, 1'b0);
        wait_quiet();
        set_thresholds(20000, 10000);
        queue_sample(5000, 1'b0, 1'b0);
        queue_sample(25000, 1'b0, 1'b0);
        queue_sample(9999, 1'b0, 1'b0);
        wait_quiet();

        // zero scale gives zero length bytes
        set_thresholds(1000, -1000);
        write_reg(REG_CPS, 24'h000000);
        queue_sample(2000, 1'b0, 1'b0);
        queue_sample(-2000, 1'b0, 1'b0);
        queue_sample(2000, 1'b0, 1'b0);
        queue_sample(-2000, 1'b0, 1'b0);
        wait_quiet();

        // full scale: pulses around the long form boundary, then a pulse
        // stretched by in-band samples that needs the long form
        write_reg(REG_CPS, CYCLE_MAX);
        queue_pulses(2, 10, 1'b0);
        queue_sample(2000, 1'b1, 1'b0);
        repeat (18)
            queue_sample(0, 1'b1, 1'b0);
        queue_sample(-2000, 1'b1, 1'b0);
        wait_quiet();

        // thresholds at the ends of the range: no flank possible
        set_thresholds(32767, -32768);
        queue_sample(32767, 1'b0, 1'b0);
        queue_sample(-32768, 1'b0, 1'b0);
        repeat (6)
            queue_sample(int'(16'($urandom)), 1'b0, 1'b0);
        wait_quiet();

        // random phases, mostly pulse trains with random content
        random_start = items_queued;
        phase        = 0;
        while (items_queued - random_start < RANDOM_ITEMS || phase < 3)
        begin
            up = rand_between(-8000, 16000);
            set_thresholds(up, up - rand_between(0, 16000));
            write_reg(REG_CPS, (phase % 2) ? CPS_W'($urandom)
                                           : CPS_W'(rand_between(1 << 16, 1 << 20)));
            rx_gap_max = (phase % 3 == 2) ? 0 : 4;
            no_idle    = (phase % 3 == 1);
            if (phase == 1)
            begin
                // receiver holds off while short pulses keep coming
                hold_requests++;
                queue_pulses(8, 2, 1'b1);
            end
            else
                queue_pulses(2, 6, no_idle);
            // sender waits for every byte before this one
            if (phase == 2)
                queue_sample(int'(16'($urandom)), no_idle, 1'b1);
            repeat (4)
                queue_sample(int'(16'($urandom)), no_idle, 1'b0);
            queue_pulses(1, 6, no_idle);
            wait_quiet();
            phase++;
        end

        $display("covered %0d samples over %0d random phases, %0d tap bytes checked",
                 samples_taken, phase, bytes_checked);
        $display("pulses: %0d single byte, %0d long form, %0d of them saturated",
                 short_pulses, long_pulses, saturated_pulses);
        if (errors == 0)
            $display("PASS tape_pulse_tap_encoder");
        else
            $display("FAIL tape_pulse_tap_encoder");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/tpte_pkg.sv
sv/tpte_fifo.sv
sv/tpte_front.sv
sv/tpte_back.sv
sv/tape_pulse_tap_encoder.sv
sv/tpte_checker.sv
tb/tape_pulse_tap_encoder_tb.sv
